// ===== hw/rtl/swm_pkg.sv =====
// Shared constants and types for the scanline window mask unit.
package swm_pkg;

   localparam int LINE_WIDTH = 256;
   localparam int POS_W = 8;
   localparam int LINE_W = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIN0_HORIZONTAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN0_VERTICAL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN1_HORIZONTAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN1_VERTICAL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSIDE_CONTROL  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTSIDE_CONTROL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_ENABLES  = 3'd6;

   localparam logic ACTION_LINE_START = 1'b0;
   localparam logic ACTION_PIXEL      = 1'b1;

   localparam logic [1:0] ACTIVE_BOTH = 2'b11;

   // Step applied to the window trackers when the staged transaction moves on.
   typedef struct packed {
      logic             line_step;
      logic             pixel_step;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] x;
   } swm_step_type;

endpackage

// ===== hw/rtl/swm_win_track.sv =====
// Active-bit tracker for one rectangular window.
module swm_win_track
   import swm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  swm_step_type          step,
   input  logic [CSR_DATA_W-1:0] horizontal,
   input  logic [CSR_DATA_W-1:0] vertical,
   input  logic                  enable,
   output logic                  covered
);

   logic [1:0] bits_ff;
   logic [1:0] bits_in;

   always_comb begin
      bits_in = bits_ff;
      if (step.line_step) begin
         if (step.line == vertical[7:0]) begin
            bits_in[0] = 1'b0;
         end else if (step.line == vertical[15:8]) begin
            bits_in[0] = 1'b1;
         end
      end
      if (step.pixel_step && enable) begin
         if (step.x == horizontal[7:0]) begin
            bits_in[1] = 1'b0;
         end else if (step.x == horizontal[15:8]) begin
            bits_in[1] = 1'b1;
         end
      end
   end

   assign covered = enable && (bits_in == ACTIVE_BOTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= 2'b00;
      end else begin
         bits_ff <= bits_in;
      end
   end

endmodule

// ===== hw/rtl/swm_mask_select.sv =====
// Priority selection of the window control byte.
module swm_mask_select
   import swm_pkg::*;
(
   input  logic                  cover0,
   input  logic                  cover1,
   input  logic                  obj_hit,
   input  logic                  obj_enable,
   input  logic [CSR_DATA_W-1:0] inside_control,
   input  logic [CSR_DATA_W-1:0] outside_control,
   output logic [7:0]            mask_byte
);

   always_comb begin
      if (cover0) begin
         mask_byte = inside_control[7:0];
      end else if (cover1) begin
         mask_byte = inside_control[15:8];
      end else if (obj_enable && obj_hit) begin
         mask_byte = outside_control[15:8];
      end else begin
         mask_byte = outside_control[7:0];
      end
   end

endmodule

// ===== hw/rtl/scanline_window_mask_unit.sv =====
// Top level of the scanline window mask unit: input stage, trackers and result register.
//
// Channel  Direction  Transaction
// req_     in         line start or pixel (tuser = action)
// rsp_     out        mask byte and position, one per in-range pixel
// csr_     in         register write, index and data, no wait
//
// A transaction is accepted every cycle unless a stalled result holds a full stage.
// The window active bits update as the staged transaction enters the result
// register, so consecutive pixels see each other's edge changes.
// A stalled result holds the input stage; reset clears the active bits,
// the control registers and both valid flags.
module scanline_window_mask_unit
   import swm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: line_number [8:0], pixel_x [16:9], obj_window_hit [17], zero [23:18]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: action [0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: mask_byte [7:0], mask_x [15:8]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CSR_DATA_W-1:0] win0_horizontal_ff;
   logic [CSR_DATA_W-1:0] win0_vertical_ff;
   logic [CSR_DATA_W-1:0] win1_horizontal_ff;
   logic [CSR_DATA_W-1:0] win1_vertical_ff;
   logic [CSR_DATA_W-1:0] inside_control_ff;
   logic [CSR_DATA_W-1:0] outside_control_ff;
   logic [2:0]            window_enables_ff;

   logic              stage_valid_ff;
   logic              stage_action_ff;
   logic [LINE_W-1:0] stage_line_ff;
   logic [POS_W-1:0]  stage_x_ff;
   logic              stage_obj_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rsp_mask_ff;
   logic [POS_W-1:0] rsp_x_ff;

   logic         rsp_free;
   logic         stage_move;
   logic         req_accept;
   logic         x_in_range;
   swm_step_type step;
   logic         cover0;
   logic         cover1;
   logic [7:0]   mask_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_horizontal_ff <= '0;
         win0_vertical_ff   <= '0;
         win1_horizontal_ff <= '0;
         win1_vertical_ff   <= '0;
         inside_control_ff  <= '0;
         outside_control_ff <= '0;
         window_enables_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIN0_HORIZONTAL: win0_horizontal_ff <= csr_wdata;
            CSR_WIN0_VERTICAL:   win0_vertical_ff   <= csr_wdata;
            CSR_WIN1_HORIZONTAL: win1_horizontal_ff <= csr_wdata;
            CSR_WIN1_VERTICAL:   win1_vertical_ff   <= csr_wdata;
            CSR_INSIDE_CONTROL:  inside_control_ff  <= csr_wdata;
            CSR_OUTSIDE_CONTROL: outside_control_ff <= csr_wdata;
            CSR_WINDOW_ENABLES:  window_enables_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign stage_move = stage_valid_ff && rsp_free;
   assign req_tready = !stage_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_action_ff <= req_tuser;
         stage_line_ff   <= req_tdata[8:0];
         stage_x_ff      <= req_tdata[16:9];
         stage_obj_ff    <= req_tdata[17];
      end
   end

   assign x_in_range = {1'b0, stage_x_ff} < LINE_W'(LINE_WIDTH);

   always_comb begin
      step.line_step  = stage_move && (stage_action_ff == ACTION_LINE_START);
      step.pixel_step = stage_move && (stage_action_ff == ACTION_PIXEL) && x_in_range;
      step.line       = stage_line_ff[7:0];
      step.x          = stage_x_ff;
   end

   swm_win_track u_win0 (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .horizontal (win0_horizontal_ff),
      .vertical   (win0_vertical_ff),
      .enable     (window_enables_ff[0]),
      .covered    (cover0)
   );

   swm_win_track u_win1 (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .horizontal (win1_horizontal_ff),
      .vertical   (win1_vertical_ff),
      .enable     (window_enables_ff[1]),
      .covered    (cover1)
   );

   swm_mask_select u_select (
      .cover0          (cover0),
      .cover1          (cover1),
      .obj_hit         (stage_obj_ff),
      .obj_enable      (window_enables_ff[2]),
      .inside_control  (inside_control_ff),
      .outside_control (outside_control_ff),
      .mask_byte       (mask_byte)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = step.pixel_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.pixel_step) begin
         rsp_mask_ff <= mask_byte;
         rsp_x_ff    <= stage_x_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_x_ff, rsp_mask_ff};

endmodule
